>>> hw/rtl/qdrt_pkg.sv
// Shared types, constants and the quarter-wave sine function of the beam tracker.
package qdrt_pkg;

	// Fixed field and state widths
	localparam int GRADE_W    = 8;
	localparam int TRIG_W     = 13;
	localparam int PERIOD_W   = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FILT_W     = 24;
	localparam int ACC_W      = 40;
	localparam int OUT_W      = 24;
	localparam int FRAC_BITS  = 15;
	localparam int TRIG_VAL_W = 16;
	localparam int OUT_TDATA_W = 56;

	// Filter arithmetic: old*grade is 33 bits, the numerator gets one guard bit,
	// and its magnitude always fits 32 bits.
	localparam int PROD_W    = FILT_W + GRADE_W + 1;
	localparam int NUM_W     = PROD_W + 1;
	localparam int DIV_W     = 32;
	localparam int DIVISOR_W = GRADE_W + 1;
	localparam int REM_W     = GRADE_W;
	localparam int DIV_STEPS = DIV_W / 2;

	// Q30 constants of the sine polynomial
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRADE   = 2'd0,
		REG_TRIGGER = 2'd1,
		REG_PERIOD  = 2'd2
	} qdrt_reg_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_FWR,
		ST_TICK,
		ST_MOVE,
		ST_OUT_H,
		ST_OUT_V,
		ST_EMIT
	} qdrt_state_t;

	// Request to the iterative divider
	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [DIVISOR_W-1:0] divisor;
	} qdrt_div_req_t;

	// Registered sine and cosine, Q1.15
	typedef struct packed {
		logic [TRIG_VAL_W-1:0] sin_v;
		logic [TRIG_VAL_W-1:0] cos_v;
	} qdrt_trig_t;

	// Sine of r/2^(angle_bits-2) of a quarter turn, rounded to Q1.15 and capped
	function automatic logic [TRIG_VAL_W-1:0] qdrt_quarter_sine(input int r, input int angle_bits);
		logic [63:0] u;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] q;
		u = 64'(r) << (32 - angle_bits);
		x = (u * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t = ONE_Q30 - x2 / 64'd72;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return q[TRIG_VAL_W-1:0];
	endfunction

endpackage

>>> hw/rtl/qdrt_divider.sv
// Iterative unsigned divider, two quotient bits per cycle.
module qdrt_divider
	import qdrt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  qdrt_div_req_t        req,
	output logic                 done,
	output logic [DIV_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic [DIV_W-1:0]     dvd_q;
	logic [DIV_W-1:0]     quo_q;
	logic [REM_W-1:0]     rem_q;
	logic [DIVISOR_W-1:0] dsr_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;

	logic [DIVISOR_W-1:0] t1;
	logic [DIVISOR_W-1:0] t2;
	logic [DIVISOR_W-1:0] r1;
	logic [DIVISOR_W-1:0] r2;
	logic                 ge1;
	logic                 ge2;

	// Two restoring steps on the narrow remainder
	always_comb begin
		t1  = {rem_q, dvd_q[DIV_W-1]};
		ge1 = (t1 >= dsr_q);
		r1  = ge1 ? (t1 - dsr_q) : t1;
		t2  = {r1[REM_W-1:0], dvd_q[DIV_W-2]};
		ge2 = (t2 >= dsr_q);
		r2  = ge2 ? (t2 - dsr_q) : t2;
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Shift dividend out and quotient in
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-3:0], 2'b00};
			quo_q <= {quo_q[DIV_W-3:0], ge1, ge2};
			rem_q <= r2[REM_W-1:0];
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

endmodule

>>> hw/rtl/qdrt_sine_rom.sv
// Quarter-wave sine table with quadrant folding; registered sine and cosine.
module qdrt_sine_rom
	import qdrt_pkg::*;
#(
	parameter int ANGLE_BITS = 10
) (
	input  logic                  clk,
	input  logic [ANGLE_BITS-1:0] angle,
	output qdrt_trig_t            trig
);

	localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
	localparam int IDX_W   = ANGLE_BITS - 1;
	localparam int R_W     = ANGLE_BITS - 2;

	logic [TRIG_VAL_W-1:0] qtab [QUARTER+1];
	logic [ANGLE_BITS-1:0] ang_c;
	logic [IDX_W-1:0]      idx_s;
	logic [IDX_W-1:0]      idx_c;
	logic                  neg_s;
	logic                  neg_c;

	// Constant quarter-wave table, endpoints included
	for (genvar i = 0; i <= QUARTER; i++) begin : g_tab
		assign qtab[i] = qdrt_quarter_sine(i, ANGLE_BITS);
	end

	// Fold both angles into the first quadrant
	always_comb begin
		ang_c = angle + ANGLE_BITS'(QUARTER);
		idx_s = angle[R_W] ? (IDX_W'(QUARTER) - {1'b0, angle[R_W-1:0]})
		                   : {1'b0, angle[R_W-1:0]};
		idx_c = ang_c[R_W] ? (IDX_W'(QUARTER) - {1'b0, ang_c[R_W-1:0]})
		                   : {1'b0, ang_c[R_W-1:0]};
		neg_s = angle[ANGLE_BITS-1];
		neg_c = ang_c[ANGLE_BITS-1];
	end

	// Register the signed table values
	always_ff @(posedge clk) begin
		trig.sin_v <= neg_s ? (TRIG_VAL_W'(0) - qtab[idx_s]) : qtab[idx_s];
		trig.cos_v <= neg_c ? (TRIG_VAL_W'(0) - qtab[idx_c]) : qtab[idx_c];
	end

endmodule

>>> hw/rtl/quad_diode_rotated_tracker_core.sv
// Top level of the quadrant photodiode beam tracker with rotated stepper targets.
// One item at a time: a new input beat is taken only once the last item has been emitted.
// The shared divider runs once per axis (two quotient bits a cycle), and the shared 41-bit adder
// takes four accumulator moves (on update items only) and two output roundings in turn.
// Reset: asynchronous, clears filters, accumulators and tick count, loads register defaults.
module quad_diode_rotated_tracker_core
	import qdrt_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int ANGLE_BITS  = 10
) (
	input  logic clk,
	input  logic arst_n,
	// diode_left_up, diode_left_down, diode_right_down, diode_right_up, encoder_angle
	input  logic                                             s_tvalid,
	output logic                                             s_tready,
	input  logic [((4*SAMPLE_BITS+ANGLE_BITS+7)/8)*8-1:0]    s_tdata,
	// step_position_h, step_position_v, moved
	output logic                                             m_tvalid,
	input  logic                                             m_tready,
	output logic [OUT_TDATA_W-1:0]                           m_tdata,
	input  logic                                             cfg_we,
	input  logic [CFG_IDX_W-1:0]                             cfg_index,
	input  logic [CFG_DATA_W-1:0]                            cfg_data
);

	localparam int DIFF_W = SAMPLE_BITS + 2;
	localparam int DELTA_W = TRIG_VAL_W + 1;
	localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
	localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};
	localparam logic signed [DELTA_W-1:0] RND     = DELTA_W'((1 << FRAC_BITS) - 1);

	qdrt_state_t state_q, state_d;

	// Configuration
	logic [GRADE_W-1:0]  grade_q;
	logic [TRIG_W-1:0]   trig_q;
	logic [PERIOD_W-1:0] period_q;

	// Item state
	logic signed [DIFF_W-1:0]  diff_h_q, diff_v_q;
	logic [ANGLE_BITS-1:0]     angle_q;
	logic                      axis_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      neg_q;
	logic signed [FILT_W-1:0]  filt_h_q, filt_v_q;
	logic [PERIOD_W-1:0]       tick_q;
	logic                      upd_q;
	logic                      hpos_q, hneg_q, vpos_q, vneg_q;
	logic [1:0]                step_q;
	logic signed [ACC_W-1:0]   pos_h_q, pos_v_q;
	logic signed [OUT_W-1:0]   res_h_q, res_v_q;
	logic signed [OUT_W-1:0]   out_h_q, out_v_q;
	logic                      out_moved_q;
	logic                      m_tvalid_q;

	// Combinational helpers
	logic signed [FILT_W-1:0]  cur_filt;
	logic signed [DIFF_W-1:0]  cur_diff;
	logic signed [NUM_W-1:0]   num;
	logic signed [NUM_W-1:0]   num_abs;
	qdrt_div_req_t             div_req;
	logic                      div_done;
	logic [DIV_W-1:0]          div_quo;
	logic signed [FILT_W-1:0]  filt_new;
	logic [PERIOD_W-1:0]       tick_nx;
	logic                      update;
	logic signed [FILT_W-1:0]  thr;
	qdrt_trig_t                trig;
	logic signed [DELTA_W-1:0] s_ext, c_ext;
	logic signed [DELTA_W-1:0] delta;
	logic                      sel_v;
	logic signed [ACC_W:0]     add_a, add_b, add_sum;
	logic signed [ACC_W-1:0]   acc_sat;
	logic signed [ACC_W-FRAC_BITS-1:0] shifted;
	logic signed [OUT_W-1:0]   out_sat;
	logic                      emit_ok;

	// Shared divider
	qdrt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sine and cosine of the held angle
	qdrt_sine_rom #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_rom (
		.clk   (clk),
		.angle (angle_q),
		.trig  (trig)
	);

	// Filter numerator and its magnitude
	always_comb begin
		cur_filt = axis_q ? filt_v_q : filt_h_q;
		cur_diff = axis_q ? diff_v_q : diff_h_q;
		num      = NUM_W'(prod_q) + (NUM_W'(cur_diff) <<< 8);
		num_abs  = num[NUM_W-1] ? -num : num;
		div_req.start    = (state_q == ST_DSTART);
		div_req.dividend = num_abs[DIV_W-1:0];
		div_req.divisor  = DIVISOR_W'(grade_q) + 1'b1;
	end

	// Signed and saturated quotient
	always_comb begin
		if (!neg_q) begin
			filt_new = (div_quo > DIV_W'(FILT_MAX)) ? FILT_MAX : $signed(div_quo[FILT_W-1:0]);
		end else begin
			filt_new = (div_quo > DIV_W'(FILT_MAX) + 1'b1) ? FILT_MIN
			         : $signed(FILT_W'(0) - div_quo[FILT_W-1:0]);
		end
	end

	// Update tick and trigger threshold
	always_comb begin
		tick_nx = tick_q + 1'b1;
		update  = (tick_nx >= period_q);
		thr     = $signed({3'b000, trig_q, 8'h00});
	end

	// Shared accumulator adder: moves, then output rounding toward zero
	always_comb begin
		s_ext = DELTA_W'($signed(trig.sin_v));
		c_ext = DELTA_W'($signed(trig.cos_v));
		sel_v = 1'b0;
		delta = '0;
		case (state_q)
			ST_MOVE: begin
				case (step_q)
					2'd0: begin
						sel_v = 1'b1;
						delta = vpos_q ? c_ext : (vneg_q ? -c_ext : '0);
					end
					2'd1: begin
						delta = vpos_q ? -s_ext : (vneg_q ? s_ext : '0);
					end
					2'd2: begin
						delta = hpos_q ? c_ext : (hneg_q ? -c_ext : '0);
					end
					default: begin
						sel_v = 1'b1;
						delta = hpos_q ? s_ext : (hneg_q ? -s_ext : '0);
					end
				endcase
			end
			ST_OUT_H: begin
				delta = pos_h_q[ACC_W-1] ? RND : '0;
			end
			ST_OUT_V: begin
				sel_v = 1'b1;
				delta = pos_v_q[ACC_W-1] ? RND : '0;
			end
			default: begin
				delta = '0;
			end
		endcase
		add_a   = (ACC_W+1)'(sel_v ? pos_v_q : pos_h_q);
		add_b   = (ACC_W+1)'(delta);
		add_sum = add_a + add_b;
		if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
			acc_sat = add_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = add_sum[ACC_W-1:0];
		end
		shifted = add_sum[ACC_W-1:FRAC_BITS];
		if (shifted[ACC_W-FRAC_BITS-1] != shifted[OUT_W-1]) begin
			out_sat = shifted[ACC_W-FRAC_BITS-1] ? OUT_MIN : OUT_MAX;
		end else begin
			out_sat = shifted[OUT_W-1:0];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		emit_ok  = !m_tvalid_q || m_tready;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DSTART;
			end
			ST_DSTART: begin
				state_d = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (div_done) begin
					state_d = ST_FWR;
				end
			end
			ST_FWR: begin
				state_d = axis_q ? ST_TICK : ST_MUL;
			end
			ST_TICK: begin
				state_d = update ? ST_MOVE : ST_OUT_H;
			end
			ST_MOVE: begin
				if (step_q == 2'd3) begin
					state_d = ST_OUT_H;
				end
			end
			ST_OUT_H: begin
				state_d = ST_OUT_V;
			end
			ST_OUT_V: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grade_q  <= GRADE_W'(7);
			trig_q   <= TRIG_W'(100);
			period_q <= PERIOD_W'(50);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRADE:   grade_q  <= cfg_data[GRADE_W-1:0];
				REG_TRIGGER: trig_q   <= cfg_data[TRIG_W-1:0];
				REG_PERIOD:  period_q <= cfg_data[PERIOD_W-1:0];
				default:     ;
			endcase
		end
	end

	// Tracker state and sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q     <= 1'b0;
			filt_h_q   <= '0;
			filt_v_q   <= '0;
			tick_q     <= '0;
			upd_q      <= 1'b0;
			step_q     <= '0;
			pos_h_q    <= '0;
			pos_v_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Raise the result beat on emit, drop it once taken
			if (state_q == ST_EMIT && emit_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					axis_q <= 1'b0;
					step_q <= '0;
				end
				ST_FWR: begin
					if (axis_q) begin
						filt_v_q <= filt_new;
					end else begin
						filt_h_q <= filt_new;
					end
					axis_q <= 1'b1;
				end
				ST_TICK: begin
					tick_q <= update ? '0 : tick_nx;
					upd_q  <= update;
				end
				ST_MOVE: begin
					step_q <= step_q + 1'b1;
					if (sel_v) begin
						pos_v_q <= acc_sat;
					end else begin
						pos_h_q <= acc_sat;
					end
				end
				default: ;
			endcase
		end
	end

	// Item payload: differences, product, flags, results
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			diff_h_q <= DIFF_W'(s_tdata[SAMPLE_BITS-1:0])
			          + DIFF_W'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])
			          - DIFF_W'(s_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS])
			          - DIFF_W'(s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
			diff_v_q <= DIFF_W'(s_tdata[SAMPLE_BITS-1:0])
			          + DIFF_W'(s_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS])
			          - DIFF_W'(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])
			          - DIFF_W'(s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
			angle_q  <= s_tdata[4*SAMPLE_BITS+ANGLE_BITS-1:4*SAMPLE_BITS];
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(cur_filt) * PROD_W'($signed({1'b0, grade_q}));
		end
		if (state_q == ST_DSTART) begin
			neg_q <= num[NUM_W-1];
		end
		if (state_q == ST_TICK) begin
			hpos_q <= (filt_h_q > thr);
			hneg_q <= (filt_h_q < -thr);
			vpos_q <= (filt_v_q > thr);
			vneg_q <= (filt_v_q < -thr);
		end
		if (state_q == ST_OUT_H) begin
			res_h_q <= out_sat;
		end
		if (state_q == ST_OUT_V) begin
			res_v_q <= out_sat;
		end
		if (state_q == ST_EMIT && emit_ok) begin
			out_h_q     <= res_h_q;
			out_v_q     <= res_v_q;
			out_moved_q <= upd_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W-2*OUT_W-1){1'b0}}, out_moved_q, out_v_q, out_h_q};

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the quadrant photodiode beam tracker core.
module testbench;
	import qdrt_pkg::*;

	localparam int SMP_W = 12;
	localparam int ANG_W = 10;
	localparam int IN_W = ((4 * SMP_W + ANG_W + 7) / 8) * 8;
	localparam int TURN = 1 << ANG_W;
	localparam int QUARTER = TURN / 4;
	localparam int SMP_MAX = (1 << SMP_W) - 1;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASES = 9;

	typedef longint unsigned u64_t;

	localparam u64_t HALF_PI_FIX = 64'd1686629713;
	localparam u64_t UNIT_FIX = 64'd1 << 30;

	typedef struct packed {
		logic signed [OUT_W-1:0] pos_h;
		logic signed [OUT_W-1:0] pos_v;
		logic                    moved;
	} tracker_out_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	qdrt_reg_t              cfg_index = REG_GRADE;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Tracker state and register copies
	int     grade_cfg = 7;
	int     trig_cfg = 100;
	int     period_cfg = 50;
	int     tick_cnt = 0;
	longint filt_h = 0;
	longint filt_v = 0;
	longint acc_h = 0;
	longint acc_v = 0;

	logic [IN_W-1:0] beat_backlog [$];
	tracker_out_t    due_positions [$];
	tracker_out_t    want;

	int src_gap = 0;
	int sink_gap = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	bit calm = 1'b0;
	int err_cnt = 0;
	int stall_cycles = 0;

	int ph_grade [PHASES] = '{0, 255, 255, 7, -1, 1, -1, -1, -1};
	int ph_trig [PHASES] = '{0, 8191, 0, 100, -1, 8190, 0, -1, -1};
	int ph_period [PHASES] = '{1, 1023, 2, 50, 3, 3, 1, -1, 1};
	int ph_count [PHASES] = '{60, 30, 60, 60, 60, 30, 60, 40, 50};

	quad_diode_rotated_tracker_core #(
		.SAMPLE_BITS(SMP_W),
		.ANGLE_BITS(ANG_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp_signed(longint v, int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi) begin
			return hi;
		end else if (v < -hi - 1) begin
			return -hi - 1;
		end
		return v;
	endfunction

	// Taylor series of sine over one quarter turn, Q30 inside, Q1.15 out
	function automatic longint quarter_wave(int r);
		u64_t x, x2, t, s, q;
		x = ((u64_t'(r) << (32 - ANG_W)) * HALF_PI_FIX) >> 30;
		x2 = (x * x) >> 30;
		t = UNIT_FIX - x2 / 72;
		t = UNIT_FIX - ((x2 * t) >> 30) / 42;
		t = UNIT_FIX - ((x2 * t) >> 30) / 20;
		t = UNIT_FIX - ((x2 * t) >> 30) / 6;
		s = (x * t) >> 30;
		q = (s + 64'd16384) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		return longint'(q);
	endfunction

	// Fold a full-turn angle onto the quarter wave
	function automatic longint sine_at(int a);
		int pos, frac;
		pos = a & (TURN - 1);
		frac = pos & (QUARTER - 1);
		case (pos / QUARTER)
			0: return quarter_wave(frac);
			1: return quarter_wave(QUARTER - frac);
			2: return -quarter_wave(frac);
			default: return -quarter_wave(QUARTER - frac);
		endcase
	endfunction

	// Filter both errors, step the accumulators on update items, report positions
	function automatic tracker_out_t advance_tracker(logic [IN_W-1:0] word);
		longint lu, ld, rd, ru, hz, vt, thr, sn, cs;
		int ang;
		tracker_out_t r;
		lu = longint'(word[SMP_W-1:0]);
		ld = longint'(word[2*SMP_W-1:SMP_W]);
		rd = longint'(word[3*SMP_W-1:2*SMP_W]);
		ru = longint'(word[4*SMP_W-1:3*SMP_W]);
		ang = int'(word[4*SMP_W+ANG_W-1:4*SMP_W]);
		hz = lu + ld - ru - rd;
		vt = lu + ru - ld - rd;
		filt_h = clamp_signed((filt_h * grade_cfg + hz * 256) / (grade_cfg + 1), FILT_W);
		filt_v = clamp_signed((filt_v * grade_cfg + vt * 256) / (grade_cfg + 1), FILT_W);
		tick_cnt = (tick_cnt + 1) & ((1 << PERIOD_W) - 1);
		r.moved = 1'b0;
		if (tick_cnt >= period_cfg) begin
			thr = longint'(trig_cfg) * 256;
			sn = sine_at(ang);
			cs = sine_at(ang + QUARTER);
			tick_cnt = 0;
			r.moved = 1'b1;
			// vertical error first, then horizontal
			if (filt_v > thr) begin
				acc_v = clamp_signed(acc_v + cs, ACC_W);
				acc_h = clamp_signed(acc_h - sn, ACC_W);
			end else if (filt_v < -thr) begin
				acc_v = clamp_signed(acc_v - cs, ACC_W);
				acc_h = clamp_signed(acc_h + sn, ACC_W);
			end
			if (filt_h > thr) begin
				acc_h = clamp_signed(acc_h + cs, ACC_W);
				acc_v = clamp_signed(acc_v + sn, ACC_W);
			end else if (filt_h < -thr) begin
				acc_h = clamp_signed(acc_h - cs, ACC_W);
				acc_v = clamp_signed(acc_v - sn, ACC_W);
			end
		end
		r.pos_h = OUT_W'(clamp_signed(acc_h / (longint'(1) << FRAC_BITS), OUT_W));
		r.pos_v = OUT_W'(clamp_signed(acc_v / (longint'(1) << FRAC_BITS), OUT_W));
		return r;
	endfunction

	function automatic logic [IN_W-1:0] mk_beat(int lu, int ld, int rd, int ru, int ang);
		return IN_W'({ANG_W'(ang), SMP_W'(ru), SMP_W'(rd), SMP_W'(ld), SMP_W'(lu)});
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	// Write all three registers back to back while the block is idle
	task automatic apply_settings(int g, int t, int p);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_GRADE;
		cfg_data <= CFG_DATA_W'(g);
		@(posedge clk);
		cfg_index <= REG_TRIGGER;
		cfg_data <= CFG_DATA_W'(t);
		@(posedge clk);
		cfg_index <= REG_PERIOD;
		cfg_data <= CFG_DATA_W'(p);
		@(posedge clk);
		cfg_we <= 1'b0;
		grade_cfg = g;
		trig_cfg = t;
		period_cfg = p;
	endtask

	// Hold until every queued beat is sent and every position has come back
	task automatic settle();
		while (beat_backlog.size() != 0 || s_tvalid || due_positions.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Source side: present queued beats, predict on each accepted one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				due_positions.push_back(advance_tracker(s_tdata));
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (beat_backlog.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(99) < src_idle_pct) begin
					src_gap <= $urandom_range(14);
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= beat_backlog.pop_front();
				end
			end
		end
	end

	// Sink side: stall in bursts, compare each result beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_positions.size() == 0) begin
					$error("unexpected result beat: step_position_h %0d step_position_v %0d moved %0d",
						$signed(m_tdata[OUT_W-1:0]), $signed(m_tdata[2*OUT_W-1:OUT_W]),
						m_tdata[2*OUT_W]);
					err_cnt++;
				end else begin
					want = due_positions.pop_front();
					if (m_tdata[OUT_W-1:0] !== want.pos_h) begin
						$error("step_position_h: expected %0d, got %0d", want.pos_h,
							$signed(m_tdata[OUT_W-1:0]));
						err_cnt++;
					end
					if (m_tdata[2*OUT_W-1:OUT_W] !== want.pos_v) begin
						$error("step_position_v: expected %0d, got %0d", want.pos_v,
							$signed(m_tdata[2*OUT_W-1:OUT_W]));
						err_cnt++;
					end
					if (m_tdata[2*OUT_W] !== want.moved) begin
						$error("moved: expected %0d, got %0d", want.moved, m_tdata[2*OUT_W]);
						err_cnt++;
					end
				end
			end
			if (sink_gap > 0) begin
				sink_gap <= sink_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(99) < sink_idle_pct) begin
				sink_gap <= $urandom_range(14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Abort when no beat or register write moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int g, t, p, sel, base, v, ang;
		int smp [4];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		src_idle_pct = 10;
		sink_idle_pct = 10;

		// reset defaults: no update within these few items
		beat_backlog.push_back(mk_beat(0, 0, 0, 0, 0));
		beat_backlog.push_back(mk_beat(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, TURN - 1));
		beat_backlog.push_back(mk_beat(SMP_MAX, 0, 0, 0, QUARTER));
		beat_backlog.push_back(mk_beat(0, 0, SMP_MAX, 0, 2 * QUARTER));
		beat_backlog.push_back(mk_beat($urandom_range(SMP_MAX), $urandom_range(SMP_MAX),
			$urandom_range(SMP_MAX), $urandom_range(SMP_MAX), $urandom_range(TURN - 1)));
		settle();

		// period dropped below the running count, unfiltered errors, threshold edge
		apply_settings(0, 100, 1);
		beat_backlog.push_back(mk_beat(100, 0, 0, 0, 0));
		beat_backlog.push_back(mk_beat(101, 0, 0, 0, 0));
		beat_backlog.push_back(mk_beat(0, 0, 101, 0, QUARTER));
		beat_backlog.push_back(mk_beat(0, SMP_MAX, 0, 0, 2 * QUARTER));
		beat_backlog.push_back(mk_beat(0, 0, 0, SMP_MAX, 3 * QUARTER));
		beat_backlog.push_back(mk_beat(SMP_MAX, SMP_MAX, SMP_MAX, SMP_MAX, TURN - 1));
		beat_backlog.push_back(mk_beat(SMP_MAX, SMP_MAX, 0, 0, QUARTER / 2));
		beat_backlog.push_back(mk_beat(SMP_MAX, 0, 0, SMP_MAX, 3 * QUARTER / 2));
		beat_backlog.push_back(mk_beat(0, SMP_MAX, SMP_MAX, 0, 5 * QUARTER / 2));
		beat_backlog.push_back(mk_beat(0, 0, SMP_MAX, SMP_MAX, 7 * QUARTER / 2));
		beat_backlog.push_back(mk_beat(SMP_MAX, 0, 0, 0, 1));
		beat_backlog.push_back(mk_beat(SMP_MAX, 0, 0, 0, QUARTER - 1));
		settle();

		// zero period acts as one; heaviest filter weight
		apply_settings(255, 0, 0);
		repeat (4) begin
			beat_backlog.push_back(mk_beat($urandom_range(SMP_MAX), $urandom_range(SMP_MAX),
				$urandom_range(SMP_MAX), $urandom_range(SMP_MAX), $urandom_range(TURN - 1)));
		end
		settle();

		// random phases over several register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			g = (ph_grade[ph] < 0) ? $urandom_range(255) : ph_grade[ph];
			t = (ph_trig[ph] < 0) ? $urandom_range(3000) : ph_trig[ph];
			p = (ph_period[ph] < 0) ? $urandom_range(1, 20) : ph_period[ph];
			apply_settings(g, t, p);
			calm = (ph == PHASES - 1);
			src_idle_pct = pick_idle();
			sink_idle_pct = pick_idle();
			for (int n = 0; n < ph_count[ph]; n++) begin
				sel = $urandom_range(99);
				base = $urandom_range(SMP_MAX);
				for (int k = 0; k < 4; k++) begin
					if (sel < 55) begin
						v = $urandom_range(SMP_MAX);
					end else if (sel < 85) begin
						// near-balanced spot: errors close to the trigger level
						v = base + $urandom_range(160) - 80;
						if (v < 0) begin
							v = 0;
						end else if (v > SMP_MAX) begin
							v = SMP_MAX;
						end
					end else begin
						v = $urandom_range(1) ? SMP_MAX : 0;
					end
					smp[k] = v;
				end
				if ($urandom_range(9) == 0) begin
					ang = $urandom_range(3) * QUARTER + ($urandom_range(1) ? QUARTER - 1 : 0);
				end else begin
					ang = $urandom_range(TURN - 1);
				end
				beat_backlog.push_back(mk_beat(smp[0], smp[1], smp[2], smp[3], ang));
			end
			settle();
		end

		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
